>>> design/qapf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapf_pkg
// Shared types, constants and the micro-op table of the attitude filter.
// ----------------------------------------------------------------------------
package qapf_pkg;

    localparam int FRAC_BITS_DEF    = 30;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ACC_W            = 68;
    localparam int PROD_W           = 66;
    localparam int OPND_W           = 33;
    localparam logic [5:0] NQ_START = 6'd27;

    localparam logic [24:0] GAIN_P_RST = 25'd838861;
    localparam logic [24:0] GAIN_I_RST = 25'd167772;
    localparam logic [24:0] PERIOD_RST = 25'd16777216;

    typedef struct packed {
        logic [24:0] gp;
        logic [24:0] gi;
        logic [24:0] sp;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] accel_z;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_x;
        logic signed [31:0] rate_z;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_x;
    } item_t;

    typedef struct packed {
        logic signed [31:0] quat_k;
        logic signed [31:0] quat_j;
        logic signed [31:0] quat_i;
        logic signed [31:0] quat_w;
    } quat_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } ds_req_t;

    typedef enum logic [4:0] {
        SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3,
        SRC_A0, SRC_A1, SRC_A2,
        SRC_G0, SRC_G1, SRC_G2,
        SRC_E0, SRC_E1, SRC_E2,
        SRC_W0, SRC_W1, SRC_W2,
        SRC_GI, SRC_GP, SRC_SP, SRC_NORM, SRC_S,
        SRC_D0, SRC_D1, SRC_D2, SRC_D3
    } src_t;

    typedef enum logic [1:0] {SH_FRAC, SH_FRAC4, SH_NONE, SH_24} shift_t;

    typedef enum logic [3:0] {
        D_NONE, D_G2X, D_G, D_E, D_IE, D_W, D_SUM, D_THETA, D_WS, D_NQ
    } dest_t;

    typedef enum logic [2:0] {NX_MUL, NX_SQRT, NX_CORD, NX_DIV, NX_OUT} next_t;

    typedef struct packed {
        src_t        a;
        src_t        b;
        shift_t      sh;
        logic        neg;
        logic        first;
        dest_t       dest;
        logic [1:0]  idx;
        next_t       nxt;
    } uop_t;

    function automatic uop_t mk(input src_t a, input src_t b, input shift_t sh,
                                input logic neg, input logic first, input dest_t d,
                                input logic [1:0] idx, input next_t nx);
        uop_t u;
        u.a     = a;
        u.b     = b;
        u.sh    = sh;
        u.neg   = neg;
        u.first = first;
        u.dest  = d;
        u.idx   = idx;
        u.nxt   = nx;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [5:0] pc);
        uop_t u;
        case (pc)
            // predicted gravity
            6'd0:  u = mk(SRC_Q1, SRC_Q3, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd1:  u = mk(SRC_Q0, SRC_Q2, SH_FRAC, 1'b1, 1'b0, D_G2X,  2'd0, NX_MUL);
            6'd2:  u = mk(SRC_Q0, SRC_Q1, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd3:  u = mk(SRC_Q2, SRC_Q3, SH_FRAC, 1'b0, 1'b0, D_G2X,  2'd1, NX_MUL);
            6'd4:  u = mk(SRC_Q0, SRC_Q0, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd5:  u = mk(SRC_Q1, SRC_Q1, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd6:  u = mk(SRC_Q2, SRC_Q2, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd7:  u = mk(SRC_Q3, SRC_Q3, SH_FRAC, 1'b0, 1'b0, D_G,    2'd2, NX_MUL);
            // error cross product
            6'd8:  u = mk(SRC_A1, SRC_G2, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd9:  u = mk(SRC_A2, SRC_G1, SH_FRAC, 1'b1, 1'b0, D_E,    2'd0, NX_MUL);
            6'd10: u = mk(SRC_A2, SRC_G0, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd11: u = mk(SRC_A0, SRC_G2, SH_FRAC, 1'b1, 1'b0, D_E,    2'd1, NX_MUL);
            6'd12: u = mk(SRC_A0, SRC_G1, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd13: u = mk(SRC_A1, SRC_G0, SH_FRAC, 1'b1, 1'b0, D_E,    2'd2, NX_MUL);
            // integral, corrected rate, sum of squares
            6'd14: u = mk(SRC_E0, SRC_GI, SH_FRAC4, 1'b0, 1'b1, D_IE,  2'd0, NX_MUL);
            6'd15: u = mk(SRC_E0, SRC_GP, SH_FRAC4, 1'b0, 1'b1, D_W,   2'd0, NX_MUL);
            6'd16: u = mk(SRC_W0, SRC_W0, SH_NONE,  1'b0, 1'b1, D_SUM, 2'd0, NX_MUL);
            6'd17: u = mk(SRC_E1, SRC_GI, SH_FRAC4, 1'b0, 1'b1, D_IE,  2'd1, NX_MUL);
            6'd18: u = mk(SRC_E1, SRC_GP, SH_FRAC4, 1'b0, 1'b1, D_W,   2'd1, NX_MUL);
            6'd19: u = mk(SRC_W1, SRC_W1, SH_NONE,  1'b0, 1'b1, D_SUM, 2'd1, NX_MUL);
            6'd20: u = mk(SRC_E2, SRC_GI, SH_FRAC4, 1'b0, 1'b1, D_IE,  2'd2, NX_MUL);
            6'd21: u = mk(SRC_E2, SRC_GP, SH_FRAC4, 1'b0, 1'b1, D_W,   2'd2, NX_MUL);
            6'd22: u = mk(SRC_W2, SRC_W2, SH_NONE,  1'b0, 1'b1, D_SUM, 2'd2, NX_SQRT);
            // rotation angle and axis
            6'd23: u = mk(SRC_NORM, SRC_SP, SH_24, 1'b0, 1'b1, D_THETA, 2'd0, NX_CORD);
            6'd24: u = mk(SRC_W0, SRC_S, SH_NONE, 1'b0, 1'b1, D_WS, 2'd0, NX_DIV);
            6'd25: u = mk(SRC_W1, SRC_S, SH_NONE, 1'b0, 1'b1, D_WS, 2'd1, NX_DIV);
            6'd26: u = mk(SRC_W2, SRC_S, SH_NONE, 1'b0, 1'b1, D_WS, 2'd2, NX_DIV);
            // quaternion product
            6'd27: u = mk(SRC_D0, SRC_Q0, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd28: u = mk(SRC_D1, SRC_Q1, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd29: u = mk(SRC_D2, SRC_Q2, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd30: u = mk(SRC_D3, SRC_Q3, SH_FRAC, 1'b1, 1'b0, D_NQ,   2'd0, NX_MUL);
            6'd31: u = mk(SRC_D0, SRC_Q1, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd32: u = mk(SRC_D1, SRC_Q0, SH_FRAC, 1'b0, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd33: u = mk(SRC_D2, SRC_Q3, SH_FRAC, 1'b0, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd34: u = mk(SRC_D3, SRC_Q2, SH_FRAC, 1'b1, 1'b0, D_NQ,   2'd1, NX_MUL);
            6'd35: u = mk(SRC_D0, SRC_Q2, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd36: u = mk(SRC_D1, SRC_Q3, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd37: u = mk(SRC_D2, SRC_Q0, SH_FRAC, 1'b0, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd38: u = mk(SRC_D3, SRC_Q1, SH_FRAC, 1'b0, 1'b0, D_NQ,   2'd2, NX_MUL);
            6'd39: u = mk(SRC_D0, SRC_Q3, SH_FRAC, 1'b0, 1'b1, D_NONE, 2'd0, NX_MUL);
            6'd40: u = mk(SRC_D1, SRC_Q2, SH_FRAC, 1'b0, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd41: u = mk(SRC_D2, SRC_Q1, SH_FRAC, 1'b1, 1'b0, D_NONE, 2'd0, NX_MUL);
            6'd42: u = mk(SRC_D3, SRC_Q0, SH_FRAC, 1'b0, 1'b0, D_NQ,   2'd3, NX_OUT);
            default: u = mk(SRC_Q0, SRC_Q0, SH_NONE, 1'b0, 1'b1, D_NONE, 2'd0, NX_OUT);
        endcase
        return u;
    endfunction

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd7;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> design/qapf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapf_cordic
// Iterative sine/cosine of the half angle: range reduction, fold, rotation.
// ----------------------------------------------------------------------------
module qapf_cordic
    import qapf_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        half,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val,
    output logic               done
);

    localparam logic [31:0]        TWO_PI_U = 32'd1686629714;
    localparam logic signed [33:0] TWO_PI   = 34'sd1686629714;
    localparam logic signed [33:0] PI       = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI  = 34'sd421657428;
    localparam logic signed [33:0] GAIN     = 34'sd652032874;
    localparam logic signed [33:0] ONE      = 34'sd1073741824;
    localparam int                 OUT_SH   = 30 - FRAC_BITS;
    localparam logic [4:0]         LAST     = 5'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MOD  = 4'b0010,
        C_ROT  = 4'b0100,
        C_FIN  = 4'b1000
    } cstate_t;

    cstate_t            state_reg, state_next;
    logic [31:0]        h_reg, h_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic signed [31:0] cos_reg, cos_next, sin_reg, sin_next;

    logic signed [33:0] hs, hs1, hf, ys, xs, at, xc, yc;
    logic               fneg;

    always_comb
    begin
        hs  = {2'b00, h_reg};
        hs1 = (hs > PI) ? hs - TWO_PI : hs;
        fneg = 1'b0;
        hf   = hs1;
        if (hs1 > HALF_PI)
        begin
            hf   = PI - hs1;
            fneg = 1'b1;
        end
        else if (hs1 < -HALF_PI)
        begin
            hf   = -PI - hs1;
            fneg = 1'b1;
        end

        ys = y_reg >>> i_reg;
        xs = x_reg >>> i_reg;
        at = {4'b0000, atan_q30(i_reg)};

        xc = (x_reg > ONE) ? ONE : ((x_reg < -ONE) ? -ONE : x_reg);
        yc = (y_reg > ONE) ? ONE : ((y_reg < -ONE) ? -ONE : y_reg);
        if (neg_reg)
            xc = -xc;

        state_next = state_reg;
        h_next     = h_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        cos_next   = cos_reg;
        sin_next   = sin_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    h_next     = half;
                    state_next = C_MOD;
                end
            end
            C_MOD:
            begin
                if (h_reg >= TWO_PI_U)
                    h_next = h_reg - TWO_PI_U;
                else
                begin
                    neg_next   = fneg;
                    z_next     = hf <<< 2;
                    x_next     = GAIN;
                    y_next     = '0;
                    i_next     = '0;
                    state_next = C_ROT;
                end
            end
            C_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == LAST)
                    state_next = C_FIN;
            end
            C_FIN:
            begin
                cos_next   = 32'(xc >>> OUT_SH);
                sin_next   = 32'(yc >>> OUT_SH);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        i_reg   <= i_next;
        neg_reg <= neg_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;
    assign done    = done_reg;

endmodule

>>> design/qapf_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapf_divsqrt
// Shared bit-serial unit: 64-bit integer square root or unsigned divide.
// ----------------------------------------------------------------------------
module qapf_divsqrt
    import qapf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ds_req_t     req,
    input  logic [63:0] opnd,
    input  logic [31:0] divisor,
    output logic [31:0] result,
    output logic        done
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_SQRT = 3'b010,
        U_DIV  = 3'b100
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [31:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [30:0] dvd_reg, dvd_next, quo_reg, quo_next;
    logic [31:0] out_reg, out_next;
    logic        done_reg, done_next;

    logic [64:0] rb;
    logic [32:0] trial;

    always_comb
    begin
        rb    = {1'b0, res_reg} + {1'b0, bit_reg};
        trial = {rem_reg, dvd_reg[30]};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        out_next   = out_reg;
        done_next  = 1'b0;

        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = '0;
                    if (req.is_div)
                    begin
                        rem_next   = {1'b0, opnd[61:31]};
                        dvd_next   = opnd[30:0];
                        dvs_next   = divisor;
                        quo_next   = '0;
                        state_next = U_DIV;
                    end
                    else
                    begin
                        n_next     = opnd;
                        res_next   = '0;
                        bit_next   = 64'd1 << 62;
                        state_next = U_SQRT;
                    end
                end
            end
            U_SQRT:
            begin
                if ({1'b0, n_reg} >= rb)
                begin
                    n_next   = n_reg - rb[63:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    out_next   = res_next[31:0];
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            U_DIV:
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = 32'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    out_next   = {1'b0, quo_next};
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
                state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        out_reg <= out_next;
    end

    assign result = out_reg;
    assign done   = done_reg;

endmodule

>>> design/qapf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapf_core
// Micro-op sequencer around one shared multiplier and accumulator; holds the
// attitude and integral state and drives the square root, divide and CORDIC.
// ----------------------------------------------------------------------------
module qapf_core
    import qapf_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  start,
    input  item_t item,
    output logic  idle,
    output logic  res_valid,
    input  logic  res_ready,
    output quat_t quat
);

    localparam logic signed [31:0]      UNIT     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] UNIT_ACC = 68'sd1 <<< FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ISS  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_CORD = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [5:0]                pc_reg, pc_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [31:0]        q_reg [4], q_next [4];
    logic signed [31:0]        nq_reg [4], nq_next [4];
    logic signed [31:0]        d_reg [4], d_next [4];
    logic signed [31:0]        ie_reg [3], ie_next [3];
    logic signed [31:0]        g_reg [3], g_next [3];
    logic signed [31:0]        e_reg [3], e_next [3];
    logic signed [31:0]        w_reg [3], w_next [3];
    logic signed [31:0]        rate_reg [3], rate_next [3];
    logic signed [31:0]        accel_reg [3], accel_next [3];
    logic [63:0]               sum_reg, sum_next;
    logic [31:0]               norm_reg, norm_next;
    logic [32:0]               theta_reg, theta_next;
    logic [61:0]               ws_mag_reg, ws_mag_next;
    logic                      ws_neg_reg, ws_neg_next;
    logic signed [31:0]        s_reg, s_next;
    logic [1:0]                div_idx_reg, div_idx_next;
    ds_req_t                   ds_req_reg, ds_req_next;
    logic                      cd_start_reg, cd_start_next;

    uop_t                      u;
    logic signed [OPND_W-1:0]  opa, opb;
    logic signed [ACC_W-1:0]   term, base, acc_new, mag;
    logic [31:0]               ds_result;
    logic                      ds_done, cd_done;
    logic signed [31:0]        cd_cos, cd_sin;

    function automatic logic signed [OPND_W-1:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [OPND_W-1:0] opnd_sel(input src_t src);
        logic signed [OPND_W-1:0] r;
        case (src)
            SRC_Q0:   r = sx(q_reg[0]);
            SRC_Q1:   r = sx(q_reg[1]);
            SRC_Q2:   r = sx(q_reg[2]);
            SRC_Q3:   r = sx(q_reg[3]);
            SRC_A0:   r = sx(accel_reg[0]);
            SRC_A1:   r = sx(accel_reg[1]);
            SRC_A2:   r = sx(accel_reg[2]);
            SRC_G0:   r = sx(g_reg[0]);
            SRC_G1:   r = sx(g_reg[1]);
            SRC_G2:   r = sx(g_reg[2]);
            SRC_E0:   r = sx(e_reg[0]);
            SRC_E1:   r = sx(e_reg[1]);
            SRC_E2:   r = sx(e_reg[2]);
            SRC_W0:   r = sx(w_reg[0]);
            SRC_W1:   r = sx(w_reg[1]);
            SRC_W2:   r = sx(w_reg[2]);
            SRC_GI:   r = {8'b0, cfg.gi};
            SRC_GP:   r = {8'b0, cfg.gp};
            SRC_SP:   r = {8'b0, cfg.sp};
            SRC_NORM: r = {1'b0, norm_reg};
            SRC_S:    r = sx(s_reg);
            SRC_D0:   r = sx(d_reg[0]);
            SRC_D1:   r = sx(d_reg[1]);
            SRC_D2:   r = sx(d_reg[2]);
            SRC_D3:   r = sx(d_reg[3]);
            default:  r = '0;
        endcase
        return r;
    endfunction

    qapf_divsqrt u_divsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ds_req_reg),
        .opnd    (ds_req_reg.is_div ? {2'b00, ws_mag_reg} : sum_reg),
        .divisor (norm_reg),
        .result  (ds_result),
        .done    (ds_done)
    );

    qapf_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cd_start_reg),
        .half    (theta_reg[32:1]),
        .cos_val (cd_cos),
        .sin_val (cd_sin),
        .done    (cd_done)
    );

    always_comb
    begin
        u   = uop_rom(pc_reg);
        opa = opnd_sel(u.a);
        opb = opnd_sel(u.b);

        case (u.sh)
            SH_FRAC:  term = ACC_W'(prod_reg >>> FRAC_BITS);
            SH_FRAC4: term = ACC_W'(prod_reg >>> (FRAC_BITS - 4));
            SH_24:    term = ACC_W'(prod_reg >>> 24);
            default:  term = ACC_W'(prod_reg);
        endcase

        if (u.first)
        begin
            case (u.dest)
                D_IE:    base = ACC_W'(ie_reg[u.idx]);
                D_W:     base = ACC_W'(rate_reg[u.idx]) + ACC_W'(ie_reg[u.idx]);
                D_SUM:   base = {4'b0000, sum_reg};
                default: base = '0;
            endcase
        end
        else
            base = acc_reg;

        acc_new = u.neg ? base - term : base + term;
        mag     = acc_new[ACC_W-1] ? -acc_new : acc_new;

        state_next    = state_reg;
        pc_next       = pc_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        q_next        = q_reg;
        nq_next       = nq_reg;
        d_next        = d_reg;
        ie_next       = ie_reg;
        g_next        = g_reg;
        e_next        = e_reg;
        w_next        = w_reg;
        rate_next     = rate_reg;
        accel_next    = accel_reg;
        sum_next      = sum_reg;
        norm_next     = norm_reg;
        theta_next    = theta_reg;
        ws_mag_next   = ws_mag_reg;
        ws_neg_next   = ws_neg_reg;
        s_next        = s_reg;
        div_idx_next  = div_idx_reg;
        ds_req_next   = '0;
        cd_start_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rate_next[0]  = item.rate_x;
                    rate_next[1]  = item.rate_y;
                    rate_next[2]  = item.rate_z;
                    accel_next[0] = item.accel_x;
                    accel_next[1] = item.accel_y;
                    accel_next[2] = item.accel_z;
                    sum_next      = '0;
                    pc_next       = '0;
                    state_next    = S_ISS;
                end
            end
            S_ISS:
            begin
                prod_next  = opa * opb;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_new;
                case (u.dest)
                    D_G2X:   g_next[u.idx]  = sat32(acc_new <<< 1);
                    D_G:     g_next[u.idx]  = sat32(acc_new);
                    D_E:     e_next[u.idx]  = sat32(acc_new);
                    D_IE:    ie_next[u.idx] = sat32(acc_new);
                    D_W:     w_next[u.idx]  = sat32(acc_new);
                    D_SUM:   sum_next       = acc_new[63:0];
                    D_THETA: theta_next     = acc_new[32:0];
                    D_WS:
                    begin
                        ws_mag_next  = mag[61:0];
                        ws_neg_next  = acc_new[ACC_W-1];
                        div_idx_next = u.idx + 2'd1;
                    end
                    D_NQ:
                    begin
                        if (acc_new > UNIT_ACC)
                            nq_next[u.idx] = UNIT;
                        else if (acc_new < -UNIT_ACC)
                            nq_next[u.idx] = -UNIT;
                        else
                            nq_next[u.idx] = acc_new[31:0];
                    end
                    default: ;
                endcase
                pc_next = pc_reg + 6'd1;
                case (u.nxt)
                    NX_SQRT:
                    begin
                        ds_req_next.start = 1'b1;
                        state_next        = S_SQRT;
                    end
                    NX_CORD:
                    begin
                        cd_start_next = 1'b1;
                        state_next    = S_CORD;
                    end
                    NX_DIV:
                    begin
                        ds_req_next.start  = 1'b1;
                        ds_req_next.is_div = 1'b1;
                        state_next         = S_DIV;
                    end
                    NX_OUT:  state_next = S_OUT;
                    default: state_next = S_ISS;
                endcase
            end
            S_SQRT:
            begin
                if (ds_done)
                begin
                    norm_next = ds_result;
                    if (ds_result == '0)
                    begin
                        d_next[0] = UNIT;
                        d_next[1] = '0;
                        d_next[2] = '0;
                        d_next[3] = '0;
                        pc_next   = NQ_START;
                    end
                    state_next = S_ISS;
                end
            end
            S_CORD:
            begin
                if (cd_done)
                begin
                    d_next[0]  = cd_cos;
                    s_next     = cd_sin;
                    state_next = S_ISS;
                end
            end
            S_DIV:
            begin
                if (ds_done)
                begin
                    d_next[div_idx_reg] = ws_neg_reg ? -ds_result : ds_result;
                    state_next          = S_ISS;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    q_next     = nq_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            ds_req_reg   <= '0;
            cd_start_reg <= 1'b0;
            q_reg[0]     <= UNIT;
            q_reg[1]     <= '0;
            q_reg[2]     <= '0;
            q_reg[3]     <= '0;
            ie_reg[0]    <= '0;
            ie_reg[1]    <= '0;
            ie_reg[2]    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            ds_req_reg   <= ds_req_next;
            cd_start_reg <= cd_start_next;
            q_reg        <= q_next;
            ie_reg       <= ie_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        nq_reg      <= nq_next;
        d_reg       <= d_next;
        g_reg       <= g_next;
        e_reg       <= e_next;
        w_reg       <= w_next;
        rate_reg    <= rate_next;
        accel_reg   <= accel_next;
        sum_reg     <= sum_next;
        norm_reg    <= norm_next;
        theta_reg   <= theta_next;
        ws_mag_reg  <= ws_mag_next;
        ws_neg_reg  <= ws_neg_next;
        s_reg       <= s_next;
        div_idx_reg <= div_idx_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_OUT);
    assign quat.quat_w = nq_reg[0];
    assign quat.quat_i = nq_reg[1];
    assign quat.quat_j = nq_reg[2];
    assign quat.quat_k = nq_reg[3];

endmodule

>>> design/quaternion_attitude_pi_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_pi_fusion
// Attitude quaternion update from one IMU sample with PI gravity correction.
//
//   port group   dir  width  content
//   s_*          in   192    rates x/y/z (Q3.28), accel x/y/z (Q1.30)
//   m_*          out  128    attitude w/i/j/k (Q1.30)
//   APB          in   32     gain_proportional, gain_integral, sample_period
//
// A sample runs 43 multiply/accumulate micro-ops, each an issue and an accumulate
// state on the shared multiplier, a 32-step square root, 24 CORDIC rotations
// and three 31-step divides. A zero corrected rate skips the angle and divides.
// s_tready is high only while the sequencer is idle; a result waiting on
// m_tready holds the next sample at its final step. Reset gives the identity.
// ----------------------------------------------------------------------------
module quaternion_attitude_pi_fusion
    import qapf_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // quat_w, quat_i, quat_j, quat_k
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic [1:0] REG_GP = 2'd0;
    localparam logic [1:0] REG_GI = 2'd1;
    localparam logic [1:0] REG_SP = 2'd2;

    cfg_t         cfg_reg, cfg_next;
    logic         m_tvalid_reg, m_tvalid_next;
    quat_t        m_tdata_reg, m_tdata_next;
    logic         core_idle, core_valid, out_free;
    quat_t        core_quat;

    assign pready   = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = core_idle;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_GP:  cfg_next.gp = pwdata[24:0];
                REG_GI:  cfg_next.gi = pwdata[24:0];
                REG_SP:  cfg_next.sp = pwdata[24:0];
                default: ;
            endcase
        end

        case (paddr[3:2])
            REG_GP:  prdata = {7'b0, cfg_reg.gp};
            REG_GI:  prdata = {7'b0, cfg_reg.gi};
            REG_SP:  prdata = {7'b0, cfg_reg.sp};
            default: prdata = '0;
        endcase

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (core_valid && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = core_quat;
        end
    end

    qapf_core #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (s_tvalid && s_tready),
        .item      (item_t'(s_tdata)),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_ready (out_free),
        .quat      (core_quat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gp   <= GAIN_P_RST;
            cfg_reg.gi   <= GAIN_I_RST;
            cfg_reg.sp   <= PERIOD_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one sample in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input transfer taken while a sample is in progress");

    // a finished result reaches the output register as soon as it is free
    a_result_move: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid && out_free |=> m_tvalid && core_idle)
        else $error("result not moved to output register");

    // attitude w and k components stay within the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> (core_quat.quat_w <= (32'sd1 <<< FRAC_BITS))
                    && (core_quat.quat_w >= -(32'sd1 <<< FRAC_BITS))
                    && (core_quat.quat_k <= (32'sd1 <<< FRAC_BITS))
                    && (core_quat.quat_k >= -(32'sd1 <<< FRAC_BITS)))
        else $error("attitude component out of range");

endmodule

>>> tb/sv/quaternion_attitude_pi_fusion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_pi_fusion_test
// Streams IMU samples into the attitude filter under random source and sink
// gaps, predicts each updated quaternion in fixed point and compares every
// output transfer field by field. Gains and sample period are reprogrammed
// over APB between phases, including the extremes.
// ----------------------------------------------------------------------------
module quaternion_attitude_pi_fusion_test;
    import qapf_pkg::*;

    localparam int FRAC       = 30;
    localparam int STEPS      = 24;
    localparam int WATCHDOG   = 20000;
    localparam int SINK_BLOCK_CYCLES = 3000;
    localparam logic [3:0] ADDR_GP = 4'd0;
    localparam logic [3:0] ADDR_GI = 4'd4;
    localparam logic [3:0] ADDR_SP = 4'd8;
    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint TWO_PI_Q28  = 1686629714;
    localparam longint ONE_Q30     = 1073741824;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [191:0]  s_tdata = '0;   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;        // quat_w, quat_i, quat_j, quat_k
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    quaternion_attitude_pi_fusion dut (.*);

    always #5 clk = ~clk;

    item_t   samples[$];
    quat_t   attitude_due[$];
    longint  att[4];
    longint  ierr[3];
    longint  kp, ki, dt;
    int      failures = 0;
    int      idle_cycles = 0;
    int      sink_hold = 0;
    bit      sink_block = 1'b0;
    bit      running = 1'b1;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shr(a * b, FRAC);
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint arctan_step(int i);
        return longint'(atan_q30(5'(i)));
    endfunction

    task automatic half_sincos(input longint unsigned half, output longint c, output longint s);
        longint h, x, y, z, nx;
        bit     flip;
        h = longint'(half % longint'(TWO_PI_Q28));
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (h > PI_Q28) h -= TWO_PI_Q28;
        if (h > HALF_PI_Q28)
        begin
            h = PI_Q28 - h;
            flip = 1'b1;
        end
        else if (h < -HALF_PI_Q28)
        begin
            h = -PI_Q28 - h;
            flip = 1'b1;
        end
        z = h * 4;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= arctan_step(i);
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        if (y > ONE_Q30) y = ONE_Q30;
        if (y < -ONE_Q30) y = -ONE_Q30;
        if (flip) x = -x;
        c = floor_shr(x, 30 - FRAC);
        s = floor_shr(y, 30 - FRAC);
    endtask

    task automatic update_attitude(input item_t it);
        longint q[4], a[3], r[3], g[3], e[3], w[3], d[4], nq[4], c, s, ip, pp, norm;
        longint unsigned sum, theta;
        quat_t  res;
        q = att;
        a[0] = it.accel_x; a[1] = it.accel_y; a[2] = it.accel_z;
        r[0] = it.rate_x;  r[1] = it.rate_y;  r[2] = it.rate_z;
        g[0] = clip32(2 * (qmul(q[1], q[3]) - qmul(q[0], q[2])));
        g[1] = clip32(2 * (qmul(q[0], q[1]) + qmul(q[2], q[3])));
        g[2] = clip32(qmul(q[0], q[0]) - qmul(q[1], q[1]) - qmul(q[2], q[2])
                      + qmul(q[3], q[3]));
        e[0] = clip32(qmul(a[1], g[2]) - qmul(a[2], g[1]));
        e[1] = clip32(qmul(a[2], g[0]) - qmul(a[0], g[2]));
        e[2] = clip32(qmul(a[0], g[1]) - qmul(a[1], g[0]));
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            ip = floor_shr(e[k] * ki, FRAC - 4);
            pp = floor_shr(e[k] * kp, FRAC - 4);
            ierr[k] = clip32(ierr[k] + ip);
            w[k] = clip32(r[k] + pp + ierr[k]);
            sum += unsigned'(w[k] * w[k]);
        end
        norm = root_floor(sum);
        if (norm == 0)
        begin
            d[0] = 64'sd1 << FRAC;
            d[1] = 0; d[2] = 0; d[3] = 0;
        end
        else
        begin
            theta = (unsigned'(norm) * unsigned'(dt)) >> 24;
            half_sincos(theta >> 1, c, s);
            d[0] = c;
            for (int k = 0; k < 3; k++) d[k + 1] = (w[k] * s) / norm;
        end
        nq[0] = qmul(d[0], q[0]) - qmul(d[1], q[1]) - qmul(d[2], q[2]) - qmul(d[3], q[3]);
        nq[1] = qmul(d[0], q[1]) + qmul(d[1], q[0]) + qmul(d[2], q[3]) - qmul(d[3], q[2]);
        nq[2] = qmul(d[0], q[2]) - qmul(d[1], q[3]) + qmul(d[2], q[0]) + qmul(d[3], q[1]);
        nq[3] = qmul(d[0], q[3]) + qmul(d[1], q[2]) - qmul(d[2], q[1]) + qmul(d[3], q[0]);
        for (int k = 0; k < 4; k++)
        begin
            if (nq[k] > ONE_Q30) nq[k] = ONE_Q30;
            if (nq[k] < -ONE_Q30) nq[k] = -ONE_Q30;
            att[k] = nq[k];
        end
        res.quat_w = 32'(att[0]);
        res.quat_i = 32'(att[1]);
        res.quat_j = 32'(att[2]);
        res.quat_k = 32'(att[3]);
        attitude_due.push_back(res);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [24:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_GP: kp = value;
            ADDR_GI: ki = value;
            default: dt = value;
        endcase
    endtask

    task automatic drain();
        while (samples.size() != 0 || s_tvalid || attitude_due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [31:0] unit_value();
        case ($urandom_range(0, 5))
            0: return 32'sh40000000;
            1: return 32'shC0000000;
            2: return 32'sd0;
            3: return 32'($urandom);
            default: return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000) >>> 0;
        endcase
    endfunction

    function automatic logic signed [31:0] rate_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return 32'($urandom);
            default: return 32'($signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000);
        endcase
    endfunction

    task automatic add_sample(input logic signed [31:0] rx, ry, rz, ax, ay, az);
        item_t it;
        it.rate_x = rx; it.rate_y = ry; it.rate_z = rz;
        it.accel_x = ax; it.accel_y = ay; it.accel_z = az;
        samples.push_back(it);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_sample(rate_value(), rate_value(), rate_value(),
                       unit_value(), unit_value(), unit_value());
    endtask

    // source
    int src_gap = 0;
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            update_attitude(s_tdata);
        if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (samples.size() != 0 && rst_n)
            begin
                s_tdata <= samples.pop_front();
                s_tvalid <= 1'b1;
                src_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                        : $urandom_range(0, 3);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink
    always @(posedge clk)
    begin
        if (sink_block)
        begin
            sink_hold <= SINK_BLOCK_CYCLES;
            m_tready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            sink_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 600)
                                                      : $urandom_range(1, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        quat_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (attitude_due.size() == 0)
            begin
                $error("unexpected attitude transfer %h", m_tdata);
                failures++;
            end
            else
            begin
                want = attitude_due.pop_front();
                if (got.quat_w !== want.quat_w)
                begin
                    $error("quat_w expected %0d actual %0d", want.quat_w, got.quat_w);
                    failures++;
                end
                if (got.quat_i !== want.quat_i)
                begin
                    $error("quat_i expected %0d actual %0d", want.quat_i, got.quat_i);
                    failures++;
                end
                if (got.quat_j !== want.quat_j)
                begin
                    $error("quat_j expected %0d actual %0d", want.quat_j, got.quat_j);
                    failures++;
                end
                if (got.quat_k !== want.quat_k)
                begin
                    $error("quat_k expected %0d actual %0d", want.quat_k, got.quat_k);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !running)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("quaternion_attitude_pi_fusion_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        att[0] = ONE_Q30; att[1] = 0; att[2] = 0; att[3] = 0;
        ierr[0] = 0; ierr[1] = 0; ierr[2] = 0;
        kp = GAIN_P_RST; ki = GAIN_I_RST; dt = PERIOD_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        running = 1'b0;
        repeat (5) @(posedge clk);
        running = 1'b1;

        // directed: reset gains, zero rate, field extremes
        add_sample(0, 0, 0, 0, 0, 32'sh40000000);
        add_sample(0, 0, 0, 32'sh40000000, 0, 0);
        add_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                   32'sh40000000, 32'sh40000000, 32'sh40000000);
        add_sample(32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'shC0000000, 32'shC0000000, 32'shC0000000);
        add_sample(32'shFFFFFFFF, 32'sh10000000, 32'shF0000000,
                   32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        add_sample(32'sh10000000, 0, 0, 0, 32'shC0000000, 0);
        add_sample(0, 32'sh30000000, 0, 0, 0, 32'shC0000000);
        drain();

        // directed: zero sample period, unit gains
        write_reg(ADDR_SP, 25'd0);
        write_reg(ADDR_GP, 25'd16777216);
        write_reg(ADDR_GI, 25'd16777216);
        add_sample(32'sh20000000, 32'sh10000000, 32'sh08000000,
                   32'sh40000000, 0, 0);
        add_sample(0, 0, 0, 0, 32'sh40000000, 0);
        add_random(4);
        drain();

        // directed: zero gains, minimum period, then all-ones register values
        write_reg(ADDR_GP, 25'd0);
        write_reg(ADDR_GI, 25'd0);
        write_reg(ADDR_SP, 25'd1);
        add_sample(0, 0, 0, 32'sh40000000, 32'sh40000000, 0);
        add_sample(32'sh7FFFFFFF, 0, 32'sh80000000, 0, 0, 0);
        add_random(3);
        drain();
        write_reg(ADDR_SP, 25'h1FFFFFF);
        write_reg(ADDR_GP, 25'h1FFFFFF);
        write_reg(ADDR_GI, 25'h1FFFFFF);
        add_random(6);
        drain();

        // random phases across settings; long sink hold-off in one of them
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(ADDR_GP, 25'($urandom_range(0, 16777216)));
            write_reg(ADDR_GI, 25'($urandom_range(0, 1677722)));
            write_reg(ADDR_SP, (phase % 2) ? 25'($urandom_range(1, 16777216))
                                           : 25'($urandom_range(1, 167772)));
            if (phase == 2)
            begin
                sink_block = 1'b1;
                add_random(20);
                repeat (2) @(posedge clk);
                sink_block = 1'b0;
            end
            add_random(200);
            drain();
        end
        write_reg(ADDR_GP, GAIN_P_RST);
        write_reg(ADDR_GI, GAIN_I_RST);
        write_reg(ADDR_SP, PERIOD_RST);
        add_random(40);
        drain();

        running = 1'b0;
        if (failures == 0)
            $display("quaternion_attitude_pi_fusion_test OK");
        else
            $display("quaternion_attitude_pi_fusion_test NOT OK");
        $finish;
    end
endmodule

>>> sim.f
design/qapf_pkg.sv
design/qapf_cordic.sv
design/qapf_divsqrt.sv
design/qapf_core.sv
design/quaternion_attitude_pi_fusion.sv
tb/sv/quaternion_attitude_pi_fusion_test.sv
